// File: src/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and helpers for the radix integer to ASCII block.
// ----------------------------------------------------------------------------
`default_nettype none

package ritoa_pkg;

  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int STEP_BITS = 8;   // quotient bits resolved per divide cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] ALPHA_OFS = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_RD,
    ST_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture new input word
    logic div_step;  // one divide cycle
    logic store;     // write finished digit
    logic rd;        // read next digit for output
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;   // current divide cycle is the final one
    logic conv_done;  // digit being stored is the last one
    logic emit_last;  // digit on the output is the least significant
  } dp_status_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r,
                                                      input logic             mode);
    logic [RADIX_W-1:0] res;
    res = r;
    if (mode) begin
      res = RADIX_HEX;
    end else if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dd;
    dd = {1'b0, d};
    if (d > DIGIT_MAX_DEC) begin
      return dd - ALPHA_OFS + CHAR_A;
    end
    return dd + CHAR_ZERO;
  endfunction

endpackage

`default_nettype wire

// File: src/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts an unsigned word to ASCII digits, most significant digit first.
// ----------------------------------------------------------------------------
// Operation: each digit comes from divide steps over the padded word (8 quotient
//   bits per cycle) and a store step, then a read and a show step per output word.
// Throughput: one input word at a time; next word taken the cycle after the
//   last digit is accepted.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
`default_nettype none

module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH      = 64,
  parameter int FIXED_HEX_DIGITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [63:0]                   in_value,
  input  wire logic [ritoa_pkg::RADIX_W-1:0] in_radix,
  input  wire logic                          in_mode,
  // result channel, one digit per word
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ritoa_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                               out_last_digit
);

  // Worst case digit count: radix 2 over the full width, or the fixed hex run.
  localparam int MAX_DIGITS = (VALUE_WIDTH > FIXED_HEX_DIGITS) ? VALUE_WIDTH
                                                               : FIXED_HEX_DIGITS;

  ritoa_pkg::ctrl_cmd_t  cmd;
  ritoa_pkg::dp_status_t status;

  // Sequencer: idle -> (divide x N -> store) per digit -> (read -> show) per digit
  ritoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Only the low VALUE_WIDTH bits of the value take part.
  ritoa_dp #(
    .VALUE_WIDTH      (VALUE_WIDTH),
    .FIXED_HEX_DIGITS (FIXED_HEX_DIGITS),
    .MAX_DIGITS       (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_value[VALUE_WIDTH-1:0]),
    .in_radix       (in_radix),
    .in_mode        (in_mode),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

`default_nettype wire

// File: src/ritoa_ctrl.sv
// ----------------------------------------------------------------------------
// ritoa_ctrl
// Sequencer: divide, store digits, then read them back one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ritoa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire ritoa_pkg::dp_status_t status,
  output ritoa_pkg::ctrl_cmd_t       cmd
);

  ritoa_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ritoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ritoa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ritoa_pkg::ST_DIV;
      end
      ritoa_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = ritoa_pkg::ST_STORE;
      end
      ritoa_pkg::ST_STORE: begin
        state_nxt = status.conv_done ? ritoa_pkg::ST_RD : ritoa_pkg::ST_DIV;
      end
      ritoa_pkg::ST_RD: begin
        state_nxt = ritoa_pkg::ST_OUT;
      end
      ritoa_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = status.emit_last ? ritoa_pkg::ST_IDLE : ritoa_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = ritoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state_r != ritoa_pkg::ST_IDLE);
    out_valid    = (state_r == ritoa_pkg::ST_OUT);
    cmd.load     = (state_r == ritoa_pkg::ST_IDLE) && in_valid;
    cmd.div_step = (state_r == ritoa_pkg::ST_DIV);
    cmd.store    = (state_r == ritoa_pkg::ST_STORE);
    cmd.rd       = (state_r == ritoa_pkg::ST_RD);
  end

endmodule

`default_nettype wire

// File: src/ritoa_dp.sv
// ----------------------------------------------------------------------------
// ritoa_dp
// Datapath: multi-bit-per-cycle long division by the radix, digit store,
// reverse readout and ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module ritoa_dp #(
  parameter int VALUE_WIDTH      = 64,
  parameter int FIXED_HEX_DIGITS = 16,
  parameter int MAX_DIGITS       = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ritoa_pkg::ctrl_cmd_t             cmd,
  output ritoa_pkg::dp_status_t                 status,
  input  wire logic [VALUE_WIDTH-1:0]           in_value,
  input  wire logic [ritoa_pkg::RADIX_W-1:0]    in_radix,
  input  wire logic                             in_mode,
  output logic      [ritoa_pkg::CHAR_W-1:0]     out_digit_char,
  output logic                                  out_last_digit
);

  localparam int NSTEP  = (VALUE_WIDTH + ritoa_pkg::STEP_BITS - 1) / ritoa_pkg::STEP_BITS;
  localparam int PAD_W  = NSTEP * ritoa_pkg::STEP_BITS;
  localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int PTR_W  = $clog2(MAX_DIGITS);
  localparam int RW     = ritoa_pkg::RADIX_W;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEP - 1);
  localparam logic [CNT_W-1:0]  CNT_FIXED = CNT_W'(FIXED_HEX_DIGITS);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_DIGITS);

  logic [PAD_W-1:0]  work_r, work_nxt;     // dividend, becomes quotient
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     radix_r;
  logic              mode_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [RW-1:0]     rd_data_r;
  logic              last_r;

  logic [RW-1:0]     mem [MAX_DIGITS];

  // STEP_BITS restoring steps on a narrow remainder
  always_comb begin
    logic [RW:0] t;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    for (int i = 0; i < ritoa_pkg::STEP_BITS; i++) begin
      t        = {rem_nxt, work_nxt[PAD_W-1]};
      work_nxt = {work_nxt[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, radix_r}) begin
        t           = t - {1'b0, radix_r};
        work_nxt[0] = 1'b1;
      end
      rem_nxt = t[RW-1:0];
    end
  end

  assign cnt_inc = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.div_step) begin
        step_r <= (step_r == STEP_LAST) ? '0 : step_r + STEP_W'(1);
      end
      if (cmd.store) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r  <= PAD_W'(in_value);
      rem_r   <= '0;
      radix_r <= ritoa_pkg::clamp_radix(in_radix, in_mode);
      mode_r  <= in_mode;
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end else if (cmd.store) begin
      rem_r <= '0;
    end
    if (cmd.store) begin
      rd_ptr_r <= cnt_r[PTR_W-1:0];
    end else if (cmd.rd) begin
      rd_ptr_r <= rd_ptr_r - PTR_W'(1);
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r[PTR_W-1:0]] <= rem_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_ptr_r];
      last_r    <= (rd_ptr_r == '0);
    end
  end

  always_comb begin
    status.div_last = (step_r == STEP_LAST);
    if (mode_r) begin
      status.conv_done = (cnt_inc == CNT_FIXED);
    end else begin
      status.conv_done = (work_r == '0) || (cnt_inc == CNT_MAX);
    end
    status.emit_last = last_r;
  end

  assign out_digit_char = ritoa_pkg::digit_to_ascii(rd_data_r);
  assign out_last_digit = last_r;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < radix_r)
    else $error("remainder not below radix");

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (radix_r >= ritoa_pkg::RADIX_MIN) && (radix_r <= ritoa_pkg::RADIX_MAX))
    else $error("radix out of range");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> cnt_r < CNT_MAX)
    else $error("digit store overflow");

endmodule

`default_nettype wire
